### hw/rtl/cbbw_pkg.sv
package cbbw_pkg;

   // field widths fixed by the item format
   localparam int COORD_W  = 16;
   localparam int DIM_W    = 12;
   localparam int PIXEL_W  = 16;
   localparam int SCREEN_W = 12;
   localparam int OFFSET_W = 22;
   localparam int CSR_INDEX_W = 1;

   // screen size after reset
   localparam logic [SCREEN_W-1:0] SCREEN_RESET = SCREEN_W'(480);

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   // source pixel item
   typedef struct packed {
      logic                       first_pixel;
      logic signed [COORD_W-1:0]  dest_x;
      logic signed [COORD_W-1:0]  dest_y;
      logic [DIM_W-1:0]           bitmap_width;
      logic [DIM_W-1:0]           bitmap_height;
      logic                       swap_bytes;
      logic [PIXEL_W-1:0]         pixel;
   } req_type;

   // framebuffer write item
   typedef struct packed {
      logic                 write_enable;
      logic [OFFSET_W-1:0]  write_offset;
      logic [PIXEL_W-1:0]   write_data;
      logic                 bitmap_done;
   } rsp_type;

endpackage

### hw/rtl/clipped_bitmap_blit_writer.sv
// Clipped bitmap blit writer: takes one 16-bit source pixel per item in row-major order and
// gives one framebuffer write item per pixel, with the write enable cleared where the pixel
// falls outside the screen_width x screen_height screen. A pixel flagged first_pixel loads
// origin, size (0 counts as 1, larger than MAX_DIM saturates) and byte-swap mode and restarts
// at column 0, row 0. It takes one item per clock unless the output stalls; an item passes
// the stage register, then the result register: the first stage steps the column/row counters
// and does the clip compares, the second forms row * screen_width + column with one 12x12
// multiply. A stalled result holds up input only once both stages are full. The user must
// write screen size registers through the csr_ port while no item is in flight; not enforced.
module clipped_bitmap_blit_writer #(
   parameter int MAX_DIM = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   // source pixel channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cbbw_pkg::req_type                  req_data,
   // framebuffer write channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cbbw_pkg::rsp_type                  rsp_data,
   // configuration writes
   input  logic                               csr_wr_en,
   input  logic [cbbw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cbbw_pkg::SCREEN_W-1:0]      csr_wdata
);

   localparam int CW = $clog2(MAX_DIM);       // column/row counter width
   localparam int DW = $clog2(MAX_DIM + 1);   // stored bitmap size width
   localparam int EW = cbbw_pkg::DIM_W + 1;   // compare width for size clamp
   localparam int SW = cbbw_pkg::COORD_W + 2; // screen position width
   localparam logic [EW-1:0] MAX_DIM_E = EW'(MAX_DIM);
   localparam int MW = 2 * cbbw_pkg::SCREEN_W;

   // first stage result
   typedef struct packed {
      logic                                 on_screen;
      logic [cbbw_pkg::SCREEN_W-1:0]        col;
      logic [cbbw_pkg::SCREEN_W-1:0]        row;
      logic [cbbw_pkg::PIXEL_W-1:0]         data;
      logic                                 last;
   } stage_type;

   logic [cbbw_pkg::SCREEN_W-1:0]    screen_width_ff;
   logic [cbbw_pkg::SCREEN_W-1:0]    screen_height_ff;
   logic signed [cbbw_pkg::COORD_W-1:0] origin_col_ff, origin_col_in;
   logic signed [cbbw_pkg::COORD_W-1:0] origin_row_ff, origin_row_in;
   logic [DW-1:0]                    blit_width_ff, blit_width_in;
   logic [DW-1:0]                    blit_height_ff, blit_height_in;
   logic [CW-1:0]                    col_count_ff, col_count_in;
   logic [CW-1:0]                    row_count_ff, row_count_in;
   logic                             swap_mode_ff, swap_mode_in;
   logic                             stage_vld_ff;
   stage_type                        stage_ff, stage_in;
   logic                             rsp_vld_ff;
   cbbw_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             rsp_adv, stage_adv, req_acc;
   logic [CW-1:0]                    col_cur, row_cur;
   logic [DW-1:0]                    col_inc, row_inc;
   logic                             col_last, row_last;
   logic signed [SW-1:0]             sx, sy;
   logic                             sx_in, sy_in;
   logic [MW-1:0]                    product;

   // size clamp: zero counts as one, above MAX_DIM saturates
   function automatic logic [DW-1:0] clamp_dim(input logic [cbbw_pkg::DIM_W-1:0] v);
      logic [EW-1:0] ve;
      ve = {1'b0, v};
      if (ve == '0)
         return DW'(1);
      else if (ve > MAX_DIM_E)
         return DW'(MAX_DIM_E);
      else
         return DW'(ve);
   endfunction

   // handshake: result register frees, then stage register frees
   assign rsp_adv   = !rsp_vld_ff || rsp_ready;
   assign stage_adv = !stage_vld_ff || rsp_adv;
   assign req_ready = stage_adv;
   assign req_acc   = req_valid && stage_adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= cbbw_pkg::SCREEN_RESET;
         screen_height_ff <= cbbw_pkg::SCREEN_RESET;
      end else if (csr_wr_en) begin
         unique case (cbbw_pkg::csr_index_type'(csr_index))
            cbbw_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            cbbw_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
         endcase
      end
   end

   // geometry of the current item: a first pixel takes its own fields
   always_comb begin
      if (req_data.first_pixel) begin
         origin_col_in  = req_data.dest_x;
         origin_row_in  = req_data.dest_y;
         blit_width_in  = clamp_dim(req_data.bitmap_width);
         blit_height_in = clamp_dim(req_data.bitmap_height);
         swap_mode_in   = req_data.swap_bytes;
         col_cur        = '0;
         row_cur        = '0;
      end else begin
         origin_col_in  = origin_col_ff;
         origin_row_in  = origin_row_ff;
         blit_width_in  = blit_width_ff;
         blit_height_in = blit_height_ff;
         swap_mode_in   = swap_mode_ff;
         col_cur        = col_count_ff;
         row_cur        = row_count_ff;
      end
   end

   // position step with wrap at bitmap edges
   always_comb begin
      col_inc  = DW'(col_cur) + DW'(1);
      row_inc  = DW'(row_cur) + DW'(1);
      col_last = (col_inc == blit_width_in);
      row_last = (row_inc == blit_height_in);
      if (col_last) begin
         col_count_in = '0;
         row_count_in = row_last ? '0 : CW'(row_inc);
      end else begin
         col_count_in = CW'(col_inc);
         row_count_in = row_cur;
      end
   end

   // screen position and clip test
   always_comb begin
      sx = SW'(origin_col_in) + SW'(col_cur);
      sy = SW'(origin_row_in) + SW'(row_cur);
      sx_in = !sx[SW-1] && (sx[SW-2:0] < (SW-1)'(screen_width_ff));
      sy_in = !sy[SW-1] && (sy[SW-2:0] < (SW-1)'(screen_height_ff));
      stage_in.on_screen = sx_in && sy_in;
      stage_in.last      = col_last && row_last;
      // off-screen pixels carry zero position and data so the offset comes out zero
      if (stage_in.on_screen) begin
         stage_in.col  = sx[cbbw_pkg::SCREEN_W-1:0];
         stage_in.row  = sy[cbbw_pkg::SCREEN_W-1:0];
         stage_in.data = swap_mode_in ? {req_data.pixel[7:0], req_data.pixel[15:8]}
                                      : req_data.pixel;
      end else begin
         stage_in.col  = '0;
         stage_in.row  = '0;
         stage_in.data = '0;
      end
   end

   // bitmap state, updated on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff  <= '0;
         origin_row_ff  <= '0;
         blit_width_ff  <= DW'(1);
         blit_height_ff <= DW'(1);
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         swap_mode_ff   <= 1'b0;
      end else if (req_acc) begin
         origin_col_ff  <= origin_col_in;
         origin_row_ff  <= origin_row_in;
         blit_width_ff  <= blit_width_in;
         blit_height_ff <= blit_height_in;
         col_count_ff   <= col_count_in;
         row_count_ff   <= row_count_in;
         swap_mode_ff   <= swap_mode_in;
      end
   end

   // first stage register
   always_ff @(posedge clock) begin
      if (reset)
         stage_vld_ff <= 1'b0;
      else if (stage_adv)
         stage_vld_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (req_acc)
         stage_ff <= stage_in;
   end

   // offset: row * pitch + column
   always_comb begin
      product              = MW'(stage_ff.row) * MW'(screen_width_ff);
      rsp_in.write_enable  = stage_ff.on_screen;
      rsp_in.write_offset  = cbbw_pkg::OFFSET_W'(product + MW'(stage_ff.col));
      rsp_in.write_data    = stage_ff.data;
      rsp_in.bitmap_done   = stage_ff.last;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_vld_ff <= 1'b0;
      else if (rsp_adv)
         rsp_vld_ff <= stage_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (rsp_adv && stage_vld_ff)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/cbbw_checker.sv
module cbbw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input cbbw_pkg::rsp_type                  rsp_data
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // item taken while output stalls fills both stages, so input must stall
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && req_ready) && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken with both stages full");

   // clipped pixels carry zero offset and data
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |->
         rsp_data.write_offset == '0 && rsp_data.write_data == '0)
      else $error("clipped pixel with nonzero fields");

endmodule

bind clipped_bitmap_blit_writer cbbw_checker u_cbbw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_DIM      = 2048;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1600;

   // expected framebuffer writes, worked out from the accepted source pixels
   class blit_scoreboard;
      cbbw_pkg::rsp_type expected_writes[$];
      int      errors;
      int      screen_cols;
      int      screen_rows;
      int      origin_col;
      int      origin_row;
      int      blit_cols;
      int      blit_rows;
      int      col_pos;
      int      row_pos;
      bit      swap_mode;

      function new();
         errors      = 0;
         screen_cols = 480;
         screen_rows = 480;
         origin_col  = 0;
         origin_row  = 0;
         blit_cols   = 0;
         blit_rows   = 0;
         col_pos     = 0;
         row_pos     = 0;
         swap_mode   = 1'b0;
      endfunction

      // zero counts as one, oversize saturates
      static function int fit_dim(int v);
         if (v == 0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function void set_screen(cbbw_pkg::csr_index_type idx,
                               logic [cbbw_pkg::SCREEN_W-1:0] value);
         if (idx == cbbw_pkg::CSR_SCREEN_WIDTH) screen_cols = int'(value);
         else screen_rows = int'(value);
      endfunction

      function int outstanding();
         return expected_writes.size();
      endfunction

      // place one accepted source pixel and queue the write it causes
      function void note_pixel(cbbw_pkg::req_type px);
         int          cols;
         int          rows;
         int          sx;
         int          sy;
         int unsigned offset;
         logic [15:0] data;
         cbbw_pkg::rsp_type want;
         if (px.first_pixel) begin
            origin_col = $signed(px.dest_x);
            origin_row = $signed(px.dest_y);
            blit_cols  = fit_dim(int'(px.bitmap_width));
            blit_rows  = fit_dim(int'(px.bitmap_height));
            swap_mode  = px.swap_bytes;
            col_pos    = 0;
            row_pos    = 0;
         end
         cols = fit_dim(blit_cols);
         rows = fit_dim(blit_rows);
         if (col_pos >= cols) col_pos = 0;
         if (row_pos >= rows) row_pos = 0;
         sx   = origin_col + col_pos;
         sy   = origin_row + row_pos;
         data = swap_mode ? {px.pixel[7:0], px.pixel[15:8]} : px.pixel;
         want = '0;
         // clip against the screen, off-screen writes carry zeros
         if (sx >= 0 && sy >= 0 && sx < screen_cols && sy < screen_rows) begin
            offset            = sy * screen_cols + sx;
            want.write_enable = 1'b1;
            want.write_offset = offset[cbbw_pkg::OFFSET_W-1:0];
            want.write_data   = data;
         end
         want.bitmap_done = (col_pos + 1 == cols) && (row_pos + 1 == rows);
         expected_writes.push_back(want);
         // step to the next position, wrapping at the bitmap end
         col_pos++;
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
         end
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      // compare one accepted write item with the oldest expectation
      function void check_write(cbbw_pkg::rsp_type got);
         cbbw_pkg::rsp_type want;
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected write item, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_writes.pop_front();
         compare_field("write_enable", want.write_enable, got.write_enable);
         compare_field("write_offset", want.write_offset, got.write_offset);
         compare_field("write_data", want.write_data, got.write_data);
         compare_field("bitmap_done", want.bitmap_done, got.bitmap_done);
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   cbbw_pkg::req_type                req_data;
   logic                             rsp_valid;
   logic                             rsp_ready;
   cbbw_pkg::rsp_type                rsp_data;
   logic                             csr_wr_en;
   logic [cbbw_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cbbw_pkg::SCREEN_W-1:0]    csr_wdata;

   blit_scoreboard sb;
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             hold_len = 0;
   int             items_sent = 0;
   int             cur_cols = 480;
   int             cur_rows = 480;
   int             cycle_count = 0;

   clipped_bitmap_blit_writer #(
      .MAX_DIM(MAX_DIM)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_pixel(req_data);
         if (rsp_valid && rsp_ready) sb.check_write(rsp_data);
      end
   end

   // result side: random stalls plus requested long hold-offs
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // offer one source pixel, with random gaps ahead of it
   task automatic send_pixel(cbbw_pkg::req_type px);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // stop offering and let every expected write come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic program_screen(logic [cbbw_pkg::SCREEN_W-1:0] cols,
                                 logic [cbbw_pkg::SCREEN_W-1:0] rows);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= cbbw_pkg::CSR_SCREEN_WIDTH;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= cbbw_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_screen(cbbw_pkg::CSR_SCREEN_WIDTH, cols);
      sb.set_screen(cbbw_pkg::CSR_SCREEN_HEIGHT, rows);
      cur_cols = int'(cols);
      cur_rows = int'(rows);
   endtask

   // first pixel carries the geometry, the rest carry junk in those fields
   task automatic send_bitmap(int dx, int dy, logic [cbbw_pkg::DIM_W-1:0] bw,
                              logic [cbbw_pkg::DIM_W-1:0] bh, bit swap, int count);
      cbbw_pkg::req_type px;
      for (int i = 0; i < count; i++) begin
         px.first_pixel   = (i == 0);
         px.dest_x        = 16'($urandom);
         px.dest_y        = 16'($urandom);
         px.bitmap_width  = 12'($urandom);
         px.bitmap_height = 12'($urandom);
         px.swap_bytes    = 1'($urandom);
         px.pixel         = 16'($urandom);
         if (i == 0) begin
            px.dest_x        = 16'(dx);
            px.dest_y        = 16'(dy);
            px.bitmap_width  = bw;
            px.bitmap_height = bh;
            px.swap_bytes    = swap;
         end
         send_pixel(px);
      end
   endtask

   // origin close to the near or far screen border
   function automatic int near_border(int span);
      if ($urandom_range(1) == 0) return int'($urandom_range(0, 16)) - 8;
      return span + int'($urandom_range(0, 16)) - 12;
   endfunction

   task automatic random_bitmap();
      int                         kind;
      int                         total;
      int                         count;
      int                         dx;
      int                         dy;
      logic [cbbw_pkg::DIM_W-1:0] bw;
      logic [cbbw_pkg::DIM_W-1:0] bh;
      kind = int'($urandom_range(99));
      bw   = 12'($urandom_range(1, 6));
      bh   = 12'($urandom_range(1, 6));
      dx   = near_border(cur_cols);
      dy   = near_border(cur_rows);
      if (kind < 5) begin
         // full-range geometry, only the first few pixels
         bw = 12'($urandom);
         bh = 12'($urandom);
         dx = int'($urandom_range(65535)) - 32768;
         dy = int'($urandom_range(65535)) - 32768;
      end else if (kind < 8) begin
         if ($urandom_range(1) == 0) bw = '0;
         else bh = '0;
      end
      total = blit_scoreboard::fit_dim(int'(bw)) * blit_scoreboard::fit_dim(int'(bh));
      if (kind < 5) count = int'($urandom_range(1, 12));
      else if (kind < 85) count = total;
      else if (kind < 93) count = int'($urandom_range(1, total));
      else count = total + int'($urandom_range(1, 5));
      send_bitmap(dx, dy, bw, bh, 1'($urandom), count);
   endtask

   task automatic pick_screen();
      unique case ($urandom_range(7))
         0: program_screen(12'd1, 12'd1);
         1: program_screen(12'd2048, 12'd2048);
         2: program_screen(12'd4095, 12'd4095);
         3: program_screen(12'd0, 12'($urandom_range(1, 40)));
         4: program_screen(12'($urandom), 12'($urandom));
         default: program_screen(12'($urandom_range(1, 40)), 12'($urandom_range(1, 40)));
      endcase
   endtask

   initial begin
      cbbw_pkg::req_type px;
      int      target;
      bit      paused;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = cbbw_pkg::CSR_SCREEN_WIDTH;
      csr_wdata = '0;
      reset     = 1'b1;
      paused    = 1'b0;
      sb        = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: pixels before any first pixel sit at the origin as 1x1 bitmaps
      req_idle_pct = 13;
      rsp_idle_pct = 52;
      px = '{first_pixel: 1'b0, dest_x: 16'sh1234, dest_y: 16'sh0567,
             bitmap_width: 12'd9, bitmap_height: 12'd7, swap_bytes: 1'b1, pixel: 16'h0000};
      send_pixel(px);
      px.pixel = 16'hffff;
      send_pixel(px);
      // zero size counts as one, swapped pixel
      send_bitmap(0, 0, 12'd0, 12'd0, 1'b1, 1);
      // right and bottom edges of the reset screen
      send_bitmap(478, 479, 12'd3, 12'd1, 1'b0, 3);
      // coordinate extremes, oversize bitmap cut short
      send_bitmap(-32768, 32767, 12'd4095, 12'd4095, 1'b1, 2);
      send_bitmap(32767, -32768, 12'd2048, 12'd1, 1'b0, 1);
      // top-left clip, then one pixel past the end wraps
      send_bitmap(-1, -1, 12'd2, 12'd2, 1'b0, 5);
      // zero screen width writes nothing
      program_screen(12'd0, 12'd480);
      send_bitmap(0, 0, 12'd1, 12'd1, 1'b0, 1);
      // widest screen, offset wraps past the 22-bit range
      program_screen(12'd4095, 12'd4095);
      send_bitmap(4093, 4094, 12'd3, 12'd2, 1'b1, 6);

      // random: three idle mixes, a few screen settings each
      for (int mode = 0; mode < 3; mode++) begin
         unique case (mode)
            0: begin req_idle_pct = 13; rsp_idle_pct = 52; end
            1: begin req_idle_pct = 52; rsp_idle_pct = 13; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int sub = 0; sub < 3; sub++) begin
            if (mode == 2 && sub == 0) begin
               // start of one row at the widest bitmap, clipped at the left
               program_screen(12'd2048, 12'd2048);
               send_bitmap(-5, 2047, 12'd2048, 12'd1, 1'b1, 64);
            end else begin
               pick_screen();
            end
            // long result stall while pixels keep coming
            if (mode == 0 && sub == 1) hold_len = 120;
            target = items_sent + RANDOM_ITEMS / 9;
            while (items_sent < target) begin
               random_bitmap();
               if (mode == 1 && sub == 1 && !paused && items_sent >= target - 90) begin
                  wait_drained();
                  paused = 1'b1;
               end
            end
         end
      end

      wait_drained();
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/cbbw_pkg.sv
hw/rtl/clipped_bitmap_blit_writer.sv
hw/rtl/cbbw_checker.sv
bench/tb_top.sv
